// ----- sv/atrc_pkg.sv -----
`timescale 1ns / 1ps
package atrc_pkg;
	localparam int BUFFER_BYTES = 512;
	localparam int CNT_W = $clog2(BUFFER_BYTES);
	localparam int WIN = 11;

	typedef enum logic [1:0] {
		FN_OPEN = 2'd0,
		FN_BYTE = 2'd1,
		FN_RSTF = 2'd2,
		FN_CLOSE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_ERROR = 3'd1,
		ST_TIMEOUT = 3'd2,
		ST_RSTF = 3'd3,
		ST_OVF = 3'd4,
		ST_CME = 3'd5,
		ST_UNEXP = 3'd6
	} status_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
		logic       batch_end;
	} in_word_t;

	typedef struct packed {
		logic [2:0] status;
		logic       done_res;
		logic [8:0] total_length;
		logic       attached;
		logic       registered;
		logic       ip_addr_ok;
		logic       socket_valid;
		logic [6:0] socket_number;
	} out_word_t;
endpackage

// ----- sv/atrc_stream_if.sv -----
`timescale 1ns / 1ps
interface atrc_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/at_response_classifier.sv -----
`timescale 1ns / 1ps
// channel | dir | word
// in      | in  | func, data_byte, batch_end
// out     | out | status, done_res, total_length, side parser flags, socket_number
// One word a cycle unless the skid stage is full; each result is registered.
// The state update is a single combinational pass over an 11-byte window.
// arst_n clears all session state; status reads timeout before any open or RSTF.
// Output register with skid stage: input stalls only when both hold words.
module at_response_classifier (
	input logic clk,
	input logic arst_n,
	atrc_stream_if.sink   in,
	atrc_stream_if.source out
);
	import atrc_pkg::*;

	logic [7:0]       win_q [WIN];
	logic [CNT_W-1:0] cnt_q;
	logic act_q, done_q, ovf_q, rstf_q, zero_q, cme_q;
	logic [2:0] rph_q;
	logic rfirst_q, rfinal_q, att_q;
	logic [2:0] aph_q;
	logic [1:0] sph_q;
	logic sok_q;
	logic [6:0] sval_q;

	out_word_t res_s1, skid_q;
	logic res_v_s1, skid_v_q;

	logic [7:0] nw [WIN];
	logic [CNT_W-1:0] n_cnt;
	logic n_act, n_done, n_ovf, n_rstf, n_zero, n_cme;
	logic [2:0] n_rph, n_aph;
	logic n_rfirst, n_rfinal, n_att;
	logic [1:0] n_sph;
	logic n_sok;
	logic [6:0] n_sval;
	out_word_t res_d;

	in_word_t iw;
	assign iw = in.payload;
	logic take;
	assign in.ready = !skid_v_q;
	assign take = in.valid && in.ready;

	function automatic logic tail(input logic [7:0] w [WIN], input logic [CNT_W-1:0] n,
			input logic [87:0] tok, input int len);
		logic m;
		m = (32'(n) >= len);
		for (int i = 0; i < WIN; i++)
			if (i < len && w[WIN-len+i] != tok[8*(len-1-i) +: 8]) m = 1'b0;
		return m;
	endfunction

	localparam logic [87:0] TK_CME  = 88'("+CME ERROR:");
	localparam logic [87:0] TK_ATT1 = 88'("+CGATT:1");
	localparam logic [87:0] TK_ATT2 = 88'("+CGATT: 1");
	localparam logic [87:0] TK_REG  = 88'("+CEREG:");
	localparam logic [87:0] TK_ADDR = 88'("+CGPADDR:");
	localparam logic [87:0] TK_SOCK = 88'("+NSOCR:");
	localparam logic [87:0] TK_OK   = 88'("OK\r\n");
	localparam logic [87:0] TK_ERR  = 88'("ERROR\r\n");

	always_comb begin
		logic [7:0] c;
		logic isd, t_err, t_ok;
		logic [10:0] nv;
		c = iw.data_byte;
		isd = (c >= "0") && (c <= "9");
		nv = '0;
		nw = win_q; n_cnt = cnt_q;
		n_act = act_q; n_done = done_q; n_ovf = ovf_q; n_rstf = rstf_q;
		n_zero = zero_q; n_cme = cme_q;
		n_rph = rph_q; n_rfirst = rfirst_q; n_rfinal = rfinal_q; n_att = att_q;
		n_aph = aph_q; n_sph = sph_q; n_sok = sok_q; n_sval = sval_q;
		case (func_t'(iw.func))
			FN_OPEN: begin
				for (int i = 0; i < WIN; i++) nw[i] = '0;
				n_cnt = '0; n_act = 1'b1; n_done = 1'b0; n_ovf = 1'b0; n_rstf = 1'b0;
				n_zero = 1'b0; n_cme = 1'b0; n_rph = '0; n_rfirst = 1'b0;
				n_rfinal = 1'b0; n_att = 1'b0; n_aph = '0; n_sph = '0;
				n_sok = 1'b0; n_sval = '0;
			end
			FN_RSTF: n_rstf = 1'b1;
			FN_CLOSE: n_act = 1'b0;
			default: begin
				if (act_q && !done_q && !ovf_q) begin
					if (cnt_q == CNT_W'(BUFFER_BYTES - 1)) begin
						n_ovf = 1'b1;
						if (cme_q || tail(win_q, cnt_q, TK_ERR, 7) || tail(win_q, cnt_q, TK_OK, 4))
							n_done = 1'b1;
					end else begin
						for (int i = 0; i < WIN-1; i++) nw[i] = win_q[i+1];
						nw[WIN-1] = c;
						n_cnt = cnt_q + 1'b1;
						if (!zero_q) begin
							if (c == 8'd0) n_zero = 1'b1;
							else begin
								if (tail(nw, n_cnt, TK_CME, 11)) n_cme = 1'b1;
								if (tail(nw, n_cnt, TK_ATT1, 8) || tail(nw, n_cnt, TK_ATT2, 9))
									n_att = 1'b1;
								case (rph_q)
									3'd0: if (tail(nw, n_cnt, TK_REG, 7)) n_rph = 3'd1;
									3'd1: if (c == ",") n_rph = 3'd3;
										else if (c != " ") begin
											n_rph = 3'd2;
											if (c == "1" || c == "5") n_rfirst = 1'b1;
										end
									3'd2: if (c == ",") n_rph = 3'd3;
									3'd3: if (c != " ") begin
											n_rph = 3'd4;
											if (c == "1" || c == "5") n_rfinal = 1'b1;
										end
									default: ;
								endcase
								case (aph_q)
									3'd0: if (tail(nw, n_cnt, TK_ADDR, 9)) n_aph = 3'd1;
									3'd1: if (c == ",") n_aph = 3'd2;
									3'd2, 3'd3: begin
										if (aph_q == 3'd2 && (c == " " || c == "\"")) n_aph = aph_q;
										else if (c == ".") n_aph = 3'd5;
										else if (c == "\r" || c == "\n" || c == "," || c == "\"")
											n_aph = 3'd4;
										else n_aph = 3'd3;
									end
									default: ;
								endcase
								case (sph_q)
									2'd0: if (tail(nw, n_cnt, TK_SOCK, 7)) n_sph = 2'd1;
									2'd1: if (isd) begin
											n_sval = 7'(c - "0"); n_sok = 1'b1; n_sph = 2'd2;
										end else if (c != " ") begin
											n_sok = 1'b0; n_sph = 2'd3;
										end
									2'd2: if (isd) begin
											nv = 11'(sval_q) * 11'd10 + 11'(c - "0");
											if (nv > 11'd127) begin
												n_sok = 1'b0; n_sval = '0; n_sph = 2'd3;
											end else n_sval = nv[6:0];
										end else n_sph = 2'd3;
									default: ;
								endcase
							end
						end
						if (iw.batch_end && (n_cme || tail(nw, n_cnt, TK_ERR, 7)
								|| tail(nw, n_cnt, TK_OK, 4)))
							n_done = 1'b1;
					end
				end
			end
		endcase
		t_err = tail(nw, n_cnt, TK_ERR, 7);
		t_ok = tail(nw, n_cnt, TK_OK, 4);
		if (n_ovf) res_d.status = ST_OVF;
		else if (n_rstf) res_d.status = ST_RSTF;
		else if (!n_done) res_d.status = ST_TIMEOUT;
		else if (n_cme) res_d.status = ST_CME;
		else if (t_err) res_d.status = ST_ERROR;
		else if (t_ok) res_d.status = ST_OK;
		else res_d.status = ST_UNEXP;
		res_d.done_res = n_done;
		res_d.total_length = 9'(n_cnt);
		res_d.attached = n_att;
		res_d.registered = (n_rph == 3'd2) ? n_rfirst : (n_rph == 3'd4) ? n_rfinal : 1'b0;
		res_d.ip_addr_ok = (n_aph == 3'd5);
		res_d.socket_valid = n_sph[1] && n_sok;
		res_d.socket_number = (n_sph[1] && n_sok) ? n_sval : 7'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN; i++) win_q[i] <= '0;
			cnt_q <= '0; act_q <= 1'b0; done_q <= 1'b0; ovf_q <= 1'b0; rstf_q <= 1'b0;
			zero_q <= 1'b0; cme_q <= 1'b0; rph_q <= '0; rfirst_q <= 1'b0;
			rfinal_q <= 1'b0; att_q <= 1'b0; aph_q <= '0; sph_q <= '0;
			sok_q <= 1'b0; sval_q <= '0;
		end else if (take) begin
			win_q <= nw; cnt_q <= n_cnt; act_q <= n_act; done_q <= n_done;
			ovf_q <= n_ovf; rstf_q <= n_rstf; zero_q <= n_zero; cme_q <= n_cme;
			rph_q <= n_rph; rfirst_q <= n_rfirst; rfinal_q <= n_rfinal; att_q <= n_att;
			aph_q <= n_aph; sph_q <= n_sph; sok_q <= n_sok; sval_q <= n_sval;
		end
	end

	// skid holds the result word when the output stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_s1 <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (res_v_s1 && !out.ready) begin
				if (take) skid_v_q <= 1'b1;
			end else begin
				res_v_s1 <= take || skid_v_q;
				skid_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_v_s1 && !out.ready) begin
			if (take) skid_q <= res_d;
		end else if (skid_v_q) res_s1 <= skid_q;
		else if (take) res_s1 <= res_d;
	end

	assign out.valid = res_v_s1;
	assign out.payload = res_s1;

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> res_v_s1) else $error("skid full with empty output");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) < BUFFER_BYTES) else $error("count past buffer");
	a_sock_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.payload.socket_valid |-> out.payload.socket_number <= 7'd127)
		else $error("bad socket");
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !(take && iw.func == FN_OPEN) |=> done_q) else $error("done lost");
endmodule
